// ===== design/cte_pkg.sv =====
// ----------------------------------------------------------------------------
// CFL time-step engine package
// Item types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package cte_pkg;

  localparam logic [31:0] Q_ONES        = 32'hFFFF_FFFF;
  localparam logic [31:0] SPEED_FLOOR   = 32'd655;
  localparam logic [31:0] CFL_RESET     = 32'd0;
  localparam logic [31:0] FIXED_RESET   = 32'd65536;
  localparam logic [1:0]  DIMS_RESET    = 2'd3;

  localparam logic [1:0]  REG_CFL_TARGET = 2'd0;
  localparam logic [1:0]  REG_FIXED_STEP = 2'd1;
  localparam logic [1:0]  REG_DIMS       = 2'd2;

  localparam logic        OP_MEASURE = 1'b0;
  localparam logic        OP_REPORT  = 1'b1;

  typedef struct packed {
    logic               op;
    logic               pass_start;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] cell_volume;
  } in_item_t;

  typedef struct packed {
    logic [31:0] cfl_number;
    logic [31:0] timestep_used;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_word_t;

endpackage

// ===== design/cte_chan_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one word per handshake from source to sink.
// ----------------------------------------------------------------------------
interface cte_chan_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cfl_time_step_engine.sv =====
// ----------------------------------------------------------------------------
// CFL time-step engine
// From accept to result valid, each word passes the shared root unit and the
//   64-step divider.
// A new word is taken only once the last is done: in_if.ready is low while
//   a word is in work and while a report word waits on out_if.ready.
// Reset (rst_n low, synchronous): registers to defaults, minimum step to all
//   ones, no result pending.
// ----------------------------------------------------------------------------
module cfl_time_step_engine (
  input  logic       clk,
  input  logic       rst_n,
  cte_chan_if.sink   in_if,
  cte_chan_if.source out_if,
  cte_chan_if.sink   cfg_if
);
  import cte_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SQ   = 10'b00_0000_0010,
    ST_SPD  = 10'b00_0000_0100,
    ST_SIZE = 10'b00_0000_1000,
    ST_CMUL = 10'b00_0001_0000,
    ST_CCMP = 10'b00_0010_0000,
    ST_MUL  = 10'b00_0100_0000,
    ST_DLD  = 10'b00_1000_0000,
    ST_DIV  = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_t;

  state_t      state_r;
  in_item_t    item_r;
  logic [31:0] cfl_r, fixed_r, min_r;
  logic [1:0]  dims_r;
  logic [5:0]  cnt_r;
  logic [63:0] x_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [21:0] y_r;
  logic [31:0] speed_r, size_r, den_r;
  logic [63:0] q_r;
  logic [31:0] drem_r;
  logic [63:0] prod_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [1:0]  nd;
  logic        steady;
  logic [31:0] dt;
  logic [31:0] mul_a, mul_b;
  logic signed [31:0] comp;
  logic [31:0] comp_mag;
  logic [34:0] sq_rem_sh, sq_trial;
  logic        sq_ge;
  logic [34:0] sq_rem_nxt;
  logic [31:0] sq_root_nxt;
  logic [21:0] y_sh;
  logic [5:0]  cb_s;
  logic [63:0] cb_b, cb_xs;
  logic [32:0] dv_rem_sh;
  logic        dv_ge;
  logic [31:0] res;

  assign nd     = (dims_r == 2'd0) ? 2'd1 : dims_r;
  assign steady = (cfl_r != 32'd0);
  assign dt     = steady ? min_r : fixed_r;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    comp = item_r.vel_x;
      2'd1:    comp = item_r.vel_y;
      default: comp = item_r.vel_z;
    endcase
    if (cnt_r[1:0] >= nd) begin
      comp = 32'sd0;
    end
    comp_mag = comp[31] ? (~comp + 32'd1) : comp;
  end

  assign y_sh = {y_r[20:0], 1'b0};

  always_comb begin
    mul_a = comp_mag;
    mul_b = comp_mag;
    case (state_r)
      ST_CMUL: begin
        mul_a = {10'd0, y_sh};
        mul_b = {10'd0, y_sh} + 32'd1;
      end
      ST_MUL: begin
        mul_a = (item_r.op == OP_REPORT) ? speed_r : cfl_r;
        mul_b = (item_r.op == OP_REPORT) ? dt : size_r;
      end
      default: ;
    endcase
  end

  assign sq_rem_sh   = {rem_r[32:0], x_r[63:62]};
  assign sq_trial    = {1'b0, root_r, 2'b01};
  assign sq_ge       = (sq_rem_sh >= sq_trial);
  assign sq_rem_nxt  = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
  assign sq_root_nxt = {root_r[30:0], sq_ge};

  assign cb_s  = 6'd63 - 6'(3 * cnt_r);
  assign cb_b  = {prod_r[62:0], 1'b0} + prod_r + 64'd1;
  assign cb_xs = x_r >> cb_s;

  assign dv_rem_sh = {drem_r, q_r[63]};
  assign dv_ge     = (dv_rem_sh >= {1'b0, den_r});
  assign res = ((den_r == 32'd0) || (q_r[63:32] != 32'd0)) ? Q_ONES : q_r[31:0];

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfl_r   <= CFL_RESET;
      fixed_r <= FIXED_RESET;
      dims_r  <= DIMS_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.index)
        REG_CFL_TARGET: cfl_r   <= cfg_if.data.data;
        REG_FIXED_STEP: fixed_r <= cfg_if.data.data;
        REG_DIMS:       dims_r  <= cfg_if.data.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= Q_ONES;
      out_valid_r <= 1'b0;
      cnt_r       <= 6'd0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            item_r  <= in_if.data;
            x_r     <= 64'd0;
            rem_r   <= 35'd0;
            root_r  <= 32'd0;
            cnt_r   <= 6'd0;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (cnt_r != 6'd0) begin
            x_r <= x_r + prod_r;
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd3) begin
            cnt_r   <= 6'd0;
            state_r <= ST_SPD;
          end
        end
        ST_SPD, ST_SIZE: begin
          x_r    <= {x_r[61:0], 2'b00};
          rem_r  <= sq_rem_nxt;
          root_r <= sq_root_nxt;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            cnt_r  <= 6'd0;
            rem_r  <= 35'd0;
            root_r <= 32'd0;
            if (state_r == ST_SIZE) begin
              size_r  <= sq_root_nxt;
              state_r <= ST_MUL;
            end else begin
              speed_r <= sq_root_nxt;
              case (nd)
                2'd1: begin
                  size_r  <= item_r.cell_volume;
                  state_r <= ST_MUL;
                end
                2'd2: begin
                  x_r     <= {16'd0, item_r.cell_volume, 16'd0};
                  state_r <= ST_SIZE;
                end
                default: begin
                  x_r     <= {item_r.cell_volume, 32'd0};
                  y_r     <= 22'd0;
                  state_r <= ST_CMUL;
                end
              endcase
            end
          end
        end
        ST_CMUL: begin
          y_r     <= y_sh;
          state_r <= ST_CCMP;
        end
        ST_CCMP: begin
          if (cb_xs >= cb_b) begin
            x_r <= x_r - (cb_b << cb_s);
            y_r <= y_r + 22'd1;
          end
          cnt_r   <= cnt_r + 6'd1;
          state_r <= ST_CMUL;
          if (cnt_r == 6'd21) begin
            cnt_r   <= 6'd0;
            size_r  <= {10'd0, y_r + 22'(cb_xs >= cb_b)};
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_DLD;
        end
        ST_DLD: begin
          q_r    <= prod_r;
          drem_r <= 32'd0;
          if (item_r.op == OP_REPORT) begin
            den_r <= size_r;
          end else begin
            den_r <= (speed_r < SPEED_FLOOR) ? SPEED_FLOOR : speed_r;
          end
          cnt_r   <= 6'd0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (dv_ge) begin
            drem_r <= 32'(dv_rem_sh - {1'b0, den_r});
          end else begin
            drem_r <= dv_rem_sh[31:0];
          end
          q_r   <= {q_r[62:0], dv_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            cnt_r   <= 6'd0;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (item_r.op == OP_MEASURE) begin
            if (steady) begin
              if (item_r.pass_start) begin
                min_r <= (res < Q_ONES) ? res : Q_ONES;
              end else if (res < min_r) begin
                min_r <= res;
              end
            end
            state_r <= ST_IDLE;
          end else if (!out_valid_r || out_if.ready) begin
            out_data_r.cfl_number    <= res;
            out_data_r.timestep_used <= dt;
            out_valid_r              <= 1'b1;
            state_r                  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/cfl_time_step_engine_tb.sv =====
// ----------------------------------------------------------------------------
// CFL time-step engine testbench
// Drives measure and report cells through the input channel and writes the
// registers through the configuration channel. It predicts each report word
// with its own Q16.16 model of the running minimum, or takes a typed row's word
// as given, then compares it field by field. A directed table comes first, then
// random passes over many settings. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module cfl_time_step_engine_tb;
  import cte_pkg::*;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } row_t;

  logic clk;
  logic rst_n;

  cte_chan_if #(.word_t(in_item_t))  in_ch ();
  cte_chan_if #(.word_t(out_item_t)) out_ch ();
  cte_chan_if #(.word_t(cfg_word_t)) cfg_ch ();

  cfl_time_step_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  logic [31:0] cfl_target_q;
  logic [31:0] fixed_step_q;
  logic [1:0]  dims_q;
  logic [31:0] min_step_q;

  out_item_t report_q[$];
  int        errors;
  int        cells_sent;
  int        reports_seen;
  int        cfg_writes;
  int        src_idle_pct;
  int        sink_stall_pct;
  int        hold_cycles = 0;
  bit        long_hold_req = 1'b0;
  bit        long_hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("cfl_time_step_engine_tb: FAIL");
    $finish;
  end

  function automatic logic [63:0] sqrt64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] cbrt64(logic [63:0] x);
    logic [63:0] y;
    logic [63:0] b;
    int s;
    y = 0;
    for (s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 64'd3 * y * (y + 64'd1) + 64'd1;
      if ((x >> s) >= b) begin
        x = x - (b << s);
        y = y + 64'd1;
      end
    end
    return y;
  endfunction

  function automatic logic [63:0] mag_sq(logic [31:0] v);
    logic [63:0] m;
    m = {32'd0, v[31] ? (~v + 32'd1) : v};
    return m * m;
  endfunction

  function automatic logic [31:0] sat_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return Q_ONES;
    q = num / den;
    return (q > 64'hFFFF_FFFF) ? Q_ONES : q[31:0];
  endfunction

  // advance the running minimum; return the report word if one is due
  task automatic step_cell(input in_item_t c, output bit has_word, output out_item_t w);
    logic [1:0]  nd;
    logic [63:0] sq;
    logic [63:0] speed;
    logic [63:0] size;
    logic [63:0] sp;
    logic [63:0] vol;
    logic [31:0] cand;
    logic [31:0] dt;
    nd = (dims_q == 2'd0) ? 2'd1 : dims_q;
    vol = {32'd0, c.cell_volume};
    sq = mag_sq(c.vel_x);
    if (nd >= 2) sq = sq + mag_sq(c.vel_y);
    if (nd >= 3) sq = sq + mag_sq(c.vel_z);
    speed = sqrt64(sq);
    if (nd == 2'd1) size = vol;
    else if (nd == 2'd2) size = sqrt64(vol << 16);
    else size = cbrt64(vol << 32);
    has_word = 1'b0;
    w = '0;
    if (c.op == OP_MEASURE) begin
      if (cfl_target_q != 0) begin
        sp = (speed < {32'd0, SPEED_FLOOR}) ? {32'd0, SPEED_FLOOR} : speed;
        cand = sat_div({32'd0, cfl_target_q} * size, sp);
        if (c.pass_start) min_step_q = Q_ONES;
        if (cand < min_step_q) min_step_q = cand;
      end
    end else begin
      dt = (cfl_target_q != 0) ? min_step_q : fixed_step_q;
      w.cfl_number = sat_div(speed * {32'd0, dt}, size);
      w.timestep_used = dt;
      has_word = 1'b1;
    end
  endtask

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_cell(input in_item_t c, input bit typed, input out_item_t want);
    int gap;
    bit has_word;
    out_item_t w;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    step_cell(c, has_word, w);
    if (has_word) report_q.push_back(typed ? want : w);
    cells_sent++;
  endtask

  // drain all report words, then let the block finish any measure cell
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_CFL_TARGET: cfl_target_q = val;
      REG_FIXED_STEP: fixed_step_q = val;
      REG_DIMS:       dims_q = val[1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      4: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000)
                                     : -$urandom_range(0, 32'h0004_0000);
      default: return $urandom_range(0, 1) ? $urandom_range(0, 1000) : -$urandom_range(0, 1000);
    endcase
  endfunction

  function automatic logic [31:0] rand_vol();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return ($urandom_range(0, 1)) ? 32'd0 : Q_ONES;
      2: return $urandom_range(1, 100);
      default: return $urandom_range(32'h0000_4000, 32'h0010_0000);
    endcase
  endfunction

  function automatic in_item_t rand_cell(logic op, logic start);
    in_item_t c;
    c.op = op;
    c.pass_start = start;
    c.vel_x = rand_vel();
    c.vel_y = rand_vel();
    c.vel_z = rand_vel();
    c.cell_volume = rand_vol();
    return c;
  endfunction

  function automatic logic [31:0] rand_reg(int sel);
    case ($urandom_range(0, 3))
      0: return (sel == 0) ? 32'd0 : Q_ONES;
      1: return (sel == 0) ? Q_ONES : 32'd0;
      2: return $urandom;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  always @(posedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      out_ch.ready   <= 1'b0;
      hold_cycles    <= 1500;
      long_hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if ($urandom_range(0, 499) == 0 && sink_stall_pct > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= $urandom_range(40, 250);
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        $display("%0t: unexpected word, actual %h/%h", $time,
                 out_ch.data.cfl_number, out_ch.data.timestep_used);
        errors++;
      end else begin
        if (out_ch.data.cfl_number !== report_q[0].cfl_number) begin
          $display("%0t: cfl_number expected %h actual %h", $time,
                   report_q[0].cfl_number, out_ch.data.cfl_number);
          errors++;
        end
        if (out_ch.data.timestep_used !== report_q[0].timestep_used) begin
          $display("%0t: timestep_used expected %h actual %h", $time,
                   report_q[0].timestep_used, out_ch.data.timestep_used);
          errors++;
        end
        void'(report_q.pop_front());
      end
    end
  end

  function automatic row_t cell_row(logic op, logic start, logic [31:0] vx, logic [31:0] vy,
                                    logic [31:0] vz, logic [31:0] vol, bit typed,
                                    logic [31:0] cfl, logic [31:0] dt);
    row_t r;
    r.is_cfg = 1'b0;
    r.cfg_index = '0;
    r.cfg_data = '0;
    r.item = '{op: op, pass_start: start, vel_x: vx, vel_y: vy, vel_z: vz, cell_volume: vol};
    r.typed = typed;
    r.want = '{cfl_number: cfl, timestep_used: dt};
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [31:0] val);
    row_t r;
    r = cell_row(OP_MEASURE, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0);
    r.is_cfg = 1'b1;
    r.cfg_index = idx;
    r.cfg_data = val;
    return r;
  endfunction

  initial begin
    row_t rows[$];
    int phase;
    int n;
    int k;
    int dims_pick;
    errors = 0;
    cells_sent = 0;
    reports_seen = 0;
    cfg_writes = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    cfl_target_q = CFL_RESET;
    fixed_step_q = FIXED_RESET;
    dims_q = DIMS_RESET;
    min_step_q = Q_ONES;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(cell_row(OP_REPORT, 0, 0, 0, 0, 32'h0001_0000, 1, 0, FIXED_RESET));
    rows.push_back(cell_row(OP_REPORT, 0, 0, 0, 0, 0, 1, Q_ONES, FIXED_RESET));
    rows.push_back(cell_row(OP_MEASURE, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h0001_0000, 0, 0, 0));
    rows.push_back(cell_row(OP_REPORT, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1,
                            32'h0001_0000, FIXED_RESET));
    rows.push_back(cell_row(OP_REPORT, 0, 32'h8000_0000, 0, 0, 32'h0001_0000, 1,
                            32'h8000_0000, FIXED_RESET));
    rows.push_back(cell_row(OP_REPORT, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            Q_ONES, 0, 0, 0));
    rows.push_back(cfg_row(REG_CFL_TARGET, 32'h0001_0000));
    rows.push_back(cell_row(OP_REPORT, 0, 0, 0, 0, 32'h0001_0000, 1, 0, Q_ONES));
    rows.push_back(cell_row(OP_MEASURE, 1, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 0));
    rows.push_back(cell_row(OP_REPORT, 0, 0, 0, 0, 32'h0001_0000, 1, 0, 32'h0001_0000));
    rows.push_back(cell_row(OP_MEASURE, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0));
    rows.push_back(cell_row(OP_REPORT, 0, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 32'h0001_0000,
                            0, 0, 0));
    rows.push_back(cell_row(OP_MEASURE, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(cell_row(OP_REPORT, 0, 0, 0, 0, 0, 1, Q_ONES, 0));
    rows.push_back(cell_row(OP_MEASURE, 1, 32'h0000_0100, 0, 0, 32'h0001_0000, 0, 0, 0));
    rows.push_back(cfg_row(REG_DIMS, 2'd1));
    rows.push_back(cell_row(OP_MEASURE, 1, 32'h0002_0000, 32'h7FFF_FFFF, 0, 32'h0003_0000,
                            0, 0, 0));
    rows.push_back(cell_row(OP_REPORT, 0, 32'hFFFF_0000, 32'h7FFF_FFFF, 0, Q_ONES, 0, 0, 0));
    rows.push_back(cfg_row(REG_DIMS, 2'd2));
    rows.push_back(cell_row(OP_MEASURE, 1, 32'h0001_0000, 32'hFFFF_0000, 0, 32'h0004_0000,
                            0, 0, 0));
    rows.push_back(cell_row(OP_REPORT, 0, 32'h0003_0000, 32'h0004_0000, 0, 32'h0004_0000,
                            0, 0, 0));
    rows.push_back(cfg_row(REG_DIMS, 2'd0));
    rows.push_back(cell_row(OP_MEASURE, 1, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 0));
    rows.push_back(cell_row(OP_REPORT, 0, 32'h0001_0000, 32'h0005_0000, 0, 32'h0002_0000,
                            0, 0, 0));
    rows.push_back(cfg_row(REG_CFL_TARGET, 32'd0));
    rows.push_back(cfg_row(REG_FIXED_STEP, Q_ONES));
    rows.push_back(cell_row(OP_REPORT, 0, 32'h7FFF_FFFF, 0, 0, 32'd1, 1, Q_ONES, Q_ONES));

    src_idle_pct = 20;
    sink_stall_pct = 20;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_reg(rows[i].cfg_index, rows[i].cfg_data);
      end else begin
        send_cell(rows[i].item, rows[i].typed, rows[i].want);
      end
    end

    for (phase = 0; phase < 9; phase++) begin
      wait_idle();
      write_reg(REG_CFL_TARGET, (phase % 4 == 3) ? 32'd0 : rand_reg(0));
      write_reg(REG_FIXED_STEP, rand_reg(1));
      dims_pick = (phase < 4) ? phase : $urandom_range(0, 3);
      write_reg(REG_DIMS, dims_pick[1:0]);
      src_idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
      sink_stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
      if (phase == 2) long_hold_req = 1'b1;
      k = 0;
      while (k < 90) begin
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) begin
          send_cell(rand_cell($urandom_range(0, 1), $urandom_range(0, 1)), 0, '0);
          k++;
        end else begin
          for (int j = 0; j < n; j++) begin
            send_cell(rand_cell(OP_MEASURE, (j == 0) ? 1'b1 : ($urandom_range(0, 19) == 0)),
                      0, '0);
          end
          for (int j = 0; j < n; j++) send_cell(rand_cell(OP_REPORT, 1'b0), 0, '0);
          k += 2 * n;
        end
      end
    end

    wait_idle();
    $display("covered %0d cells, %0d report words, %0d register writes",
             cells_sent, reports_seen, cfg_writes);
    $display("steady and unsteady modes, dims 0 to 3, saturation and idle/stall mixes");
    if (errors == 0) begin
      $display("cfl_time_step_engine_tb: PASS");
    end else begin
      $display("cfl_time_step_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
